// File: rtl/pls_pkg.sv
package pls_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int POS_W        = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} st_t;

	typedef struct packed {
		logic [63:0]        code;
		logic [63:0]        name;
		logic signed [31:0] price;
	} record_t;

	typedef struct packed {
		op_t                op;
		logic [POS_W-1:0]   position;
		logic [63:0]        item_code;
		logic [63:0]        item_name;
		logic signed [31:0] item_price;
	} request_t;

	typedef struct packed {
		logic               status;
		logic [POS_W-1:0]   found_position;
		logic [63:0]        out_code;
		logic [63:0]        out_name;
		logic signed [31:0] out_price;
		logic [POS_W-1:0]   list_length;
	} result_t;

	// per-word strobes seen by every cell, high only in the accept cycle
	typedef struct packed {
		logic ins;
		logic del;
		logic get;
		logic loc;
	} cell_ctl_t;

endpackage

// File: rtl/pls_cell.sv
module pls_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                clk,
	input  pls_pkg::cell_ctl_t  ctl,
	input  logic [CW-1:0]       p0,
	input  logic [CW-1:0]       cnt,
	input  pls_pkg::record_t    item,
	input  pls_pkg::record_t    prev,
	input  pls_pkg::record_t    next,
	output pls_pkg::record_t    rec,
	output logic                hit
);

	localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
	localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

	pls_pkg::record_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX == p0) begin
				rec_q <= item;
			end else if (MY_IDX > p0 && MY_IDX <= cnt) begin
				rec_q <= prev;
			end
		end else if (ctl.del) begin
			// close the gap: every entry from the deleted slot up takes its upper neighbor
			if (MY_IDX >= p0 && NXT_IDX < cnt) begin
				rec_q <= next;
			end
		end
	end

	always_comb begin
		hit = (ctl.get && MY_IDX == p0) ||
		      (ctl.loc && MY_IDX < cnt && rec_q == item);
	end

	assign rec = rec_q;

endmodule

// File: rtl/pls_tree.sv
module pls_tree #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
	parameter int LEVELS   = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              leaf_hit [CAPACITY],
	input  pls_pkg::record_t  leaf_rec [CAPACITY],
	output logic              root_hit,
	output logic [LEVELS-1:0] root_idx,
	output pls_pkg::record_t  root_rec
);

	localparam int NLEAF = 1 << LEVELS;

	// heap order: node n combines 2n and 2n+1, leaves sit at NLEAF..2*NLEAF-1
	logic              hit_q [1:2*NLEAF-1];
	logic [LEVELS-1:0] idx_q [1:2*NLEAF-1];
	pls_pkg::record_t  rec_q [1:2*NLEAF-1];

	genvar n;
	generate
		for (n = 1; n < NLEAF; n++) begin : g_node
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hit_q[n] <= 1'b0;
				end else begin
					hit_q[n] <= hit_q[2*n] | hit_q[2*n+1];
				end
			end

			// lower position wins
			always_ff @(posedge clk) begin
				if (hit_q[2*n]) begin
					idx_q[n] <= idx_q[2*n];
					rec_q[n] <= rec_q[2*n];
				end else begin
					idx_q[n] <= idx_q[2*n+1];
					rec_q[n] <= rec_q[2*n+1];
				end
			end
		end

		for (n = 0; n < NLEAF; n++) begin : g_leaf
			if (n < CAPACITY) begin : g_real
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						hit_q[NLEAF+n] <= 1'b0;
					end else if (load) begin
						hit_q[NLEAF+n] <= leaf_hit[n];
					end
				end

				always_ff @(posedge clk) begin
					if (load) begin
						idx_q[NLEAF+n] <= LEVELS'(n);
						rec_q[NLEAF+n] <= leaf_rec[n];
					end
				end
			end else begin : g_pad
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						hit_q[NLEAF+n] <= 1'b0;
					end else if (load) begin
						hit_q[NLEAF+n] <= 1'b0;
					end
				end

				always_ff @(posedge clk) begin
					if (load) begin
						idx_q[NLEAF+n] <= LEVELS'(n);
						rec_q[NLEAF+n] <= '0;
					end
				end
			end
		end
	endgenerate

	assign root_hit = hit_q[1];
	assign root_idx = idx_q[1];
	assign root_rec = rec_q[1];

endmodule

// File: rtl/positional_list_store.sv
// channel   signals                   handshake
// request   start, busy, request      word taken when start && !busy
// result    done, result              word valid for the one cycle done is high
//
// Insert and delete: every cell shifts in parallel at the take and the
// result word shows in the next cycle, when a new word can already be taken.
// Get and locate: the result word is set by the registered first-hit tree once the scan
// ends; busy covers the wait, so no new word is taken before then.
// After reset the list is empty and a word can be taken at once.
// The receiver cannot stall; done is a one-cycle strobe.
module positional_list_store #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pls_pkg::request_t request,
	output logic              done,
	output pls_pkg::result_t  result
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int EW     = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
	localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LVW    = $clog2(LEVELS + 1);

	pls_pkg::st_t       state_q, state_d;
	logic [LVW-1:0]     lvl_q;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic               done_q;
	pls_pkg::result_t   res_q;
	pls_pkg::result_t   res_acc;
	logic               pend_get_q;
	logic               pend_err_q;

	logic               accept;
	logic               scan_end;
	logic [EW-1:0]      pos_e, cnt_e;
	logic               ins_range, not_full, in_list;
	pls_pkg::cell_ctl_t ctl;
	logic [CW-1:0]      p0;
	pls_pkg::record_t   item;

	pls_pkg::record_t   cell_rec [CAPACITY];
	logic               cell_hit [CAPACITY];

	logic               root_hit;
	logic [LEVELS-1:0]  root_idx;
	pls_pkg::record_t   root_rec;
	logic [LEVELS:0]    fpos;

	assign item  = '{code: request.item_code, name: request.item_name,
	                 price: request.item_price};
	assign pos_e = EW'(request.position);
	assign cnt_e = EW'(cnt_q);
	assign p0    = CW'(pos_e - EW'(1));

	always_comb begin
		ins_range = (pos_e != '0) && (pos_e <= cnt_e + EW'(1));
		not_full  = (cnt_q != CW'(CAPACITY));
		in_list   = (pos_e != '0) && (pos_e <= cnt_e);
	end

	always_comb begin
		ctl = '0;
		case (request.op)
			pls_pkg::OP_INSERT: ctl.ins = accept && ins_range && not_full;
			pls_pkg::OP_DELETE: ctl.del = accept && in_list;
			pls_pkg::OP_GET:    ctl.get = accept && in_list;
			pls_pkg::OP_LOCATE: ctl.loc = accept;
			default:            ctl = '0;
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ctl.ins) begin
			cnt_d = cnt_q + CW'(1);
		end else if (ctl.del) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	// control FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		busy     = 1'b0;
		scan_end = 1'b0;
		case (state_q)
			pls_pkg::ST_IDLE: begin
				if (start && (request.op == pls_pkg::OP_GET ||
				              request.op == pls_pkg::OP_LOCATE)) begin
					state_d = pls_pkg::ST_SCAN;
				end
			end
			pls_pkg::ST_SCAN: begin
				busy = 1'b1;
				if (lvl_q == LVW'(LEVELS)) begin
					scan_end = 1'b1;
					state_d  = pls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pls_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= scan_end ||
			          (accept && (request.op == pls_pkg::OP_INSERT ||
			                      request.op == pls_pkg::OP_DELETE));
			if (accept) begin
				lvl_q <= '0;
			end else if (state_q == pls_pkg::ST_SCAN) begin
				lvl_q <= lvl_q + LVW'(1);
			end
		end
	end

	assign fpos = {1'b0, root_idx} + (LEVELS+1)'(1);

	// result word as it stands at the accept edge
	always_comb begin
		res_acc             = '0;
		res_acc.status      = (request.op == pls_pkg::OP_INSERT) ? !(ins_range && not_full)
		                                                         : !in_list;
		res_acc.list_length = pls_pkg::POS_W'(cnt_d);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_get_q <= (request.op == pls_pkg::OP_GET);
			pend_err_q <= !in_list;
			res_q      <= res_acc;
		end else if (scan_end) begin
			res_q.list_length <= pls_pkg::POS_W'(cnt_q);
			if (pend_get_q) begin
				res_q.status         <= pend_err_q;
				res_q.found_position <= '0;
				res_q.out_code       <= root_hit ? root_rec.code  : '0;
				res_q.out_name       <= root_hit ? root_rec.name  : '0;
				res_q.out_price      <= root_hit ? root_rec.price : '0;
			end else begin
				res_q.status         <= 1'b0;
				res_q.found_position <= root_hit ? pls_pkg::POS_W'(fpos) : '0;
				res_q.out_code       <= '0;
				res_q.out_name       <= '0;
				res_q.out_price      <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			pls_pkg::record_t prev_w, next_w;
			if (i == 0) begin : g_first
				assign prev_w = item;
			end else begin : g_mid_prev
				assign prev_w = cell_rec[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign next_w = item;
			end else begin : g_mid_next
				assign next_w = cell_rec[i+1];
			end

			pls_cell #(
				.IDX (i),
				.CW  (CW)
			) u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.p0   (p0),
				.cnt  (cnt_q),
				.item (item),
				.prev (prev_w),
				.next (next_w),
				.rec  (cell_rec[i]),
				.hit  (cell_hit[i])
			);
		end
	endgenerate

	pls_tree #(
		.CAPACITY (CAPACITY),
		.LEVELS   (LEVELS)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.leaf_hit (cell_hit),
		.leaf_rec (cell_rec),
		.root_hit (root_hit),
		.root_idx (root_idx),
		.root_rec (root_rec)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the list");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while a scan is still running");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !scan_end) |=> busy && cnt_q == $past(cnt_q))
		else $error("scan dropped busy early or list changed");

endmodule

// File: tb/positional_list_store_tb.sv
`timescale 1ns / 100ps

module positional_list_store_tb;
	import pls_pkg::*;

	localparam int LIST_CAP    = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;
	localparam int PRINT_CAP   = 40;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	// shadow copy of the list, advanced as each word is taken
	record_t  shadow_list [LIST_CAP];
	int       shadow_len;
	result_t  pending_results [$];
	record_t  stock_records [8];
	int       idle_pct;
	int       mismatch_count;
	int       cycle_count;

	positional_list_store dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[positional_list_store] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
	endtask

	function automatic result_t apply_list_op(input request_t w);
		result_t r;
		int      p;
		int      k;
		r = '0;
		p = int'(w.position);
		case (w.op)
			OP_INSERT: begin
				if (p < 1 || p > shadow_len + 1 || shadow_len >= LIST_CAP) begin
					r.status = 1'b1;
				end else begin
					for (k = shadow_len; k >= p; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[p-1] = {w.item_code, w.item_name, w.item_price};
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > shadow_len) begin
					r.status = 1'b1;
				end else begin
					for (k = p; k < shadow_len; k++)
						shadow_list[k-1] = shadow_list[k];
					shadow_len--;
				end
			end
			OP_GET: begin
				if (p < 1 || p > shadow_len) begin
					r.status = 1'b1;
				end else begin
					r.out_code  = shadow_list[p-1].code;
					r.out_name  = shadow_list[p-1].name;
					r.out_price = shadow_list[p-1].price;
				end
			end
			default: begin
				// first hit wins
				for (k = shadow_len - 1; k >= 0; k--)
					if (shadow_list[k] == {w.item_code, w.item_name, w.item_price})
						r.found_position = POS_W'(k + 1);
			end
		endcase
		r.list_length = POS_W'(shadow_len);
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 64'(result), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.found_position !== want.found_position)
					report_mismatch("found_position", 64'(result.found_position),
						64'(want.found_position));
				if (result.out_code !== want.out_code)
					report_mismatch("out_code", result.out_code, want.out_code);
				if (result.out_name !== want.out_name)
					report_mismatch("out_name", result.out_name, want.out_name);
				if (result.out_price !== want.out_price)
					report_mismatch("out_price", 64'($unsigned(result.out_price)),
						64'($unsigned(want.out_price)));
				if (result.list_length !== want.list_length)
					report_mismatch("list_length", 64'(result.list_length),
						64'(want.list_length));
			end
		end
	end

	// word is taken at the first edge with start high and busy low
	task automatic send_word(input request_t w);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(apply_list_op(w));
	endtask

	function automatic request_t make_word(input op_t op, input logic [POS_W-1:0] pos,
			input record_t rec);
		request_t w;
		w.op         = op;
		w.position   = pos;
		w.item_code  = rec.code;
		w.item_name  = rec.name;
		w.item_price = rec.price;
		return w;
	endfunction

	function automatic record_t random_record();
		record_t rec;
		int      sel;
		sel = $urandom_range(99);
		rec = stock_records[$urandom_range(7)];
		if (sel < 20) begin
			rec = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end else if (sel < 40) begin
			// near miss: one bit off in one field
			case ($urandom_range(2))
				0: rec.code ^= 64'd1 << $urandom_range(63);
				1: rec.name ^= 64'd1 << $urandom_range(63);
				default: rec.price ^= 32'sd1 << $urandom_range(31);
			endcase
		end
		return rec;
	endfunction

	function automatic logic [POS_W-1:0] pick_position(input op_t op);
		int sel;
		int top;
		sel = $urandom_range(99);
		top = (op == OP_INSERT) ? shadow_len + 1 : shadow_len;
		if (sel < 6)
			return POS_W'($urandom_range(127));
		if (sel < 10)
			return '0;
		if (sel < 15)
			return POS_W'(top + 1);
		if (top == 0)
			return POS_W'(1);
		if (sel < 25)
			return POS_W'(top);
		if (sel < 32)
			return POS_W'(1);
		return POS_W'($urandom_range(top, 1));
	endfunction

	task automatic test_empty_and_edges();
		record_t rec_ones, rec_zero, rec_tail, rec_mid, rec_miss;
		int      k;
		rec_ones = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF};
		rec_zero = {64'd0, 64'd0, 32'sh8000_0000};
		rec_tail = {64'd0, 64'd0, 32'sd0};
		rec_mid  = {64'hFFFF_FFFF_FFFF_FFFF, 64'd0, -32'sd1};
		rec_miss = rec_ones;
		rec_miss.price = 32'sh7FFF_FFFE;
		idle_pct = 35;
		// empty list: everything positional fails, locate misses
		send_word(make_word(OP_GET, 7'd1, rec_ones));
		send_word(make_word(OP_DELETE, 7'd1, rec_ones));
		send_word(make_word(OP_LOCATE, 7'd0, rec_tail));
		send_word(make_word(OP_INSERT, 7'd0, rec_ones));
		send_word(make_word(OP_INSERT, 7'd2, rec_ones));
		// build zero, mid, ones, tail
		send_word(make_word(OP_INSERT, 7'd1, rec_ones));
		send_word(make_word(OP_INSERT, 7'd1, rec_zero));
		send_word(make_word(OP_INSERT, 7'd3, rec_tail));
		send_word(make_word(OP_INSERT, 7'd2, rec_mid));
		send_word(make_word(OP_GET, 7'd0, rec_ones));
		send_word(make_word(OP_GET, 7'd5, rec_ones));
		send_word(make_word(OP_GET, 7'd127, rec_ones));
		for (k = 1; k <= 4; k++)
			send_word(make_word(OP_GET, POS_W'(k), rec_zero));
		send_word(make_word(OP_LOCATE, 7'd0, rec_ones));
		send_word(make_word(OP_LOCATE, 7'd0, rec_miss));
		send_word(make_word(OP_LOCATE, 7'd127, rec_tail));
		send_word(make_word(OP_DELETE, 7'd0, rec_ones));
		send_word(make_word(OP_DELETE, 7'd5, rec_ones));
		send_word(make_word(OP_DELETE, 7'd2, rec_ones));
		send_word(make_word(OP_DELETE, 7'd3, rec_ones));
		send_word(make_word(OP_INSERT, 7'd127, rec_mid));
		send_word(make_word(OP_GET, 7'd1, rec_ones));
	endtask

	task automatic test_fill_to_capacity();
		record_t rec;
		idle_pct = 35;
		while (shadow_len < LIST_CAP) begin
			// reuse a stored record now and then so locate sees duplicates
			if (shadow_len > 0 && $urandom_range(9) == 0)
				rec = shadow_list[$urandom_range(shadow_len - 1)];
			else
				rec = random_record();
			send_word(make_word(OP_INSERT, POS_W'($urandom_range(shadow_len + 1, 1)), rec));
		end
		rec = random_record();
		send_word(make_word(OP_INSERT, POS_W'(LIST_CAP + 1), rec));
		send_word(make_word(OP_INSERT, 7'd1, rec));
		send_word(make_word(OP_GET, POS_W'(LIST_CAP), rec));
		send_word(make_word(OP_LOCATE, 7'd0, shadow_list[LIST_CAP-1]));
		send_word(make_word(OP_DELETE, POS_W'(LIST_CAP), rec));
		send_word(make_word(OP_INSERT, POS_W'(LIST_CAP), rec));
		send_word(make_word(OP_LOCATE, 7'd0, rec));
		send_word(make_word(OP_DELETE, 7'd1, rec));
	endtask

	task automatic test_list_traffic(input int n_words, input int insert_pct,
			input int delete_pct, input int idle_setting);
		int      n;
		int      sel;
		op_t     op;
		record_t rec;
		idle_pct = idle_setting;
		for (n = 0; n < n_words; n++) begin
			sel = $urandom_range(99);
			if (sel < insert_pct)
				op = OP_INSERT;
			else if (sel < insert_pct + delete_pct)
				op = OP_DELETE;
			else if ($urandom_range(1) == 0)
				op = OP_GET;
			else
				op = OP_LOCATE;
			if (op == OP_LOCATE && shadow_len > 0 && $urandom_range(1) == 0)
				rec = shadow_list[$urandom_range(shadow_len - 1)];
			else
				rec = random_record();
			send_word(make_word(op, pick_position(op), rec));
		end
	endtask

	initial begin
		int k;
		start          <= 1'b0;
		request        <= '0;
		arst_n         <= 1'b0;
		shadow_len     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		idle_pct       = 35;
		stock_records[0] = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh8000_0000};
		stock_records[1] = {64'd0, 64'd0, 32'sh7FFF_FFFF};
		for (k = 2; k < 8; k++)
			stock_records[k] = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_edges();
		test_fill_to_capacity();
		test_list_traffic(245, 60, 15, 35);
		test_list_traffic(245, 20, 50, 0);
		test_list_traffic(245, 65, 10, 35);
		test_list_traffic(245, 35, 25, 35);
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("[positional_list_store] OK");
		else
			$display("[positional_list_store] ERROR");
		$finish;
	end

endmodule
